[design/command_frame_deframer_crc16_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the command frame deframer
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_DEFRAMER_CRC16_UNIT_ASSERT_SVH
`define COMMAND_FRAME_DEFRAMER_CRC16_UNIT_ASSERT_SVH

// same-cycle implication
`define CFDC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfdc same-cycle check failed");

// next-cycle implication
`define CFDC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfdc next-cycle check failed");

`endif

[design/cfdc_pkg.sv]
// ----------------------------------------------------------------------------
// cfdc_pkg
// Types, codes and the CRC-16 byte update shared by the deframer modules.
// ----------------------------------------------------------------------------
package cfdc_pkg;

	localparam int MAX_ARGS_DEF = 32;
	localparam int CNT_W        = 6;
	localparam int JOB_DEPTH    = 2;
	localparam int CFG_IDX_W    = 2;

	localparam logic [31:0] HEADER_RESET     = 32'hEB90_5B6A;
	localparam logic [31:0] FOOTER_RESET     = 32'hC5A4_D279;
	localparam logic [5:0]  ARGC_LIMIT_RESET = 6'd32;
	localparam logic [15:0] CRC_POLY         = 16'h8408;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOOTER     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ARGC_LIMIT = 2'd2;

	localparam logic [1:0] KIND_SUMMARY = 2'd0;
	localparam logic [1:0] KIND_ARG     = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [2:0] ERR_SHORT  = 3'd0;
	localparam logic [2:0] ERR_HEADER = 3'd1;
	localparam logic [2:0] ERR_COUNT  = 3'd2;
	localparam logic [2:0] ERR_CRC    = 3'd3;
	localparam logic [2:0] ERR_FOOTER = 3'd4;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CODE,
		PH_ARGS,
		PH_TAIL,
		PH_HOLD
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_LOAD
	} back_state_t;

	// one decided frame, handed from parser to emitter
	typedef struct packed {
		logic             is_err;
		logic [2:0]       err_code;
		logic [15:0]      code;
		logic [CNT_W-1:0] count;
	} job_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [15:0]      code;
		logic [CNT_W-1:0] count;
		logic [4:0]       index;
		logic [31:0]      value;
		logic [2:0]       err_code;
		logic             last;
	} result_t;

	// reflected CRC-16, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[design/command_frame_deframer_crc16_unit.sv]
// ----------------------------------------------------------------------------
// command_frame_deframer_crc16_unit
// Sync-word framed command deframer with CRC-16 (reflected 0x8408, init 0).
// ----------------------------------------------------------------------------
// Input channel: one byte of the received buffer per request (rx_byte), with
// buffer_end on the last byte, handshaken by in_valid / in_stall.
// Output channel: one result per request (kind, command_code, arg_count,
// arg_index, arg_value, error_code, last), handshaken by out_valid / out_stall.
// Config channel: cfg_valid / cfg_ready with cfg_index 0 header, 1 footer,
// 2 argument count limit; cfg_ready is always high. Write only while idle.
// Throughput: the parser takes one byte per cycle while in_stall is low. A
// decided frame is queued (two deep) to the emitter; its first result goes
// through the queue entry, then the output register. The summary or error is
// a single output register load, each argument an argument RAM read, then an
// output register load. Argument bytes of the next frame are held off while a
// replay is queued or running, and any byte is held off while the queue is full.
// Reset clears parser, queue and emitter; registers return to defaults. The
// argument RAM is not cleared. A stalled output holds its result and the
// parser keeps running until the queue fills.
// ----------------------------------------------------------------------------
module command_frame_deframer_crc16_unit #(
	parameter int MAX_ARGS = cfdc_pkg::MAX_ARGS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	input  logic                          buffer_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [15:0]                   command_code,
	output logic [5:0]                    arg_count,
	output logic [4:0]                    arg_index,
	output logic [31:0]                   arg_value,
	output logic [2:0]                    error_code,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cfdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	`include "command_frame_deframer_crc16_unit_assert.svh"

	localparam int AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

	logic [31:0]       header_q;
	logic [31:0]       footer_q;
	logic [5:0]        argc_limit_q;
	logic              job_push, job_pop, job_full, job_empty;
	cfdc_pkg::job_t    job_in, job_head;
	logic              back_busy, arg_busy;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [31:0]       ram_wdata, ram_rdata;
	cfdc_pkg::result_t result;

	assign cfg_ready = 1'b1;
	assign arg_busy  = back_busy || !job_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q     <= cfdc_pkg::HEADER_RESET;
			footer_q     <= cfdc_pkg::FOOTER_RESET;
			argc_limit_q <= cfdc_pkg::ARGC_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cfdc_pkg::CFG_HEADER:     header_q     <= cfg_data;
				cfdc_pkg::CFG_FOOTER:     footer_q     <= cfg_data;
				cfdc_pkg::CFG_ARGC_LIMIT: argc_limit_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	cfdc_front #(.MAX_ARGS(MAX_ARGS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.buffer_end  (buffer_end),
		.header_word (header_q),
		.footer_word (footer_q),
		.argc_limit  (argc_limit_q),
		.job_full    (job_full),
		.arg_busy    (arg_busy),
		.job_push    (job_push),
		.job_data    (job_in),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata)
	);

	cfdc_ram #(.WIDTH(32), .DEPTH(MAX_ARGS)) u_arg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cfdc_job_fifo u_job_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.pop       (job_pop),
		.head      (job_head),
		.full      (job_full),
		.empty     (job_empty)
	);

	cfdc_back #(.MAX_ARGS(MAX_ARGS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty),
		.job_head  (job_head),
		.job_pop   (job_pop),
		.busy      (back_busy),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign kind         = result.kind;
	assign command_code = result.code;
	assign arg_count    = result.count;
	assign arg_index    = result.index;
	assign arg_value    = result.value;
	assign error_code   = result.err_code;
	assign last         = result.last;

	// parser must never overwrite arguments still queued for replay
	`CFDC_ASSERT_IMP(a_no_store_during_replay, ram_we, !arg_busy)
	`CFDC_ASSERT_IMP(a_no_push_when_full, job_push, !job_full)
	`CFDC_ASSERT_IMP(a_no_pop_when_empty, job_pop, !job_empty)
	`CFDC_ASSERT_NXT(a_replay_follows_summary,
		job_pop && !job_head.is_err && job_head.count != '0, back_busy)

endmodule

[design/cfdc_ram.sv]
// ----------------------------------------------------------------------------
// cfdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfdc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/cfdc_front.sv]
// ----------------------------------------------------------------------------
// cfdc_front
// Byte parser: header/code/count checks, CRC, argument capture, tail checks.
// Pushes one job per decided frame or short buffer.
// ----------------------------------------------------------------------------
module cfdc_front #(
	parameter int MAX_ARGS = cfdc_pkg::MAX_ARGS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            in_valid,
	output logic                                            in_stall,
	input  logic [7:0]                                      rx_byte,
	input  logic                                            buffer_end,
	input  logic [31:0]                                     header_word,
	input  logic [31:0]                                     footer_word,
	input  logic [5:0]                                      argc_limit,
	input  logic                                            job_full,
	input  logic                                            arg_busy,
	output logic                                            job_push,
	output cfdc_pkg::job_t                                  job_data,
	output logic                                            ram_we,
	output logic [((MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1)-1:0] ram_waddr,
	output logic [31:0]                                     ram_wdata
);

	localparam int AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

	cfdc_pkg::phase_t              phase_q, phase_n;
	logic [7:0]                    pos_q, pos_n;
	logic [15:0]                   crc_q, crc_n;
	logic [31:0]                   shift_q, shift_n;
	logic [15:0]                   code_q, code_n;
	logic [cfdc_pkg::CNT_W-1:0]    count_q, count_n;
	logic                          skip_q, skip_n;
	logic                          accept;
	logic                          decided;
	logic [31:0]                   shifted;
	logic [15:0]                   crc_byte;

	// argument bytes wait while a replay is queued or running; all bytes wait while the queue is full
	assign in_stall = job_full || (phase_q == cfdc_pkg::PH_ARGS && !skip_q && arg_busy);
	assign accept   = in_valid && !in_stall;
	assign shifted  = {shift_q[23:0], rx_byte};
	assign crc_byte = cfdc_pkg::crc16_byte(crc_q, rx_byte);

	assign ram_waddr = pos_q[2 +: AW];
	assign ram_wdata = shifted;

	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		crc_n    = crc_q;
		shift_n  = shift_q;
		code_n   = code_q;
		count_n  = count_q;
		skip_n   = skip_q;
		job_push = 1'b0;
		job_data = '0;
		ram_we   = 1'b0;
		decided  = 1'b0;

		if (accept) begin
			if (skip_q) begin
				if (buffer_end) begin
					phase_n = cfdc_pkg::PH_HEADER;
					pos_n   = '0;
					crc_n   = '0;
					shift_n = '0;
					code_n  = '0;
					count_n = '0;
					skip_n  = 1'b0;
				end
			end else begin
				shift_n = shifted;
				unique case (phase_q)
					cfdc_pkg::PH_HEADER: begin
						crc_n = crc_byte;
						pos_n = pos_q + 8'd1;
						if (pos_q == 8'd3) begin
							shift_n = '0;
							if (shifted != header_word) begin
								code_n  = {13'd0, cfdc_pkg::ERR_HEADER};
								phase_n = cfdc_pkg::PH_HOLD;
							end else begin
								phase_n = cfdc_pkg::PH_CODE;
							end
						end
					end
					cfdc_pkg::PH_CODE: begin
						crc_n = crc_byte;
						pos_n = pos_q + 8'd1;
						if (pos_q == 8'd5) begin
							code_n  = shifted[15:0];
							shift_n = '0;
						end else if (pos_q == 8'd7) begin
							shift_n = '0;
							if (shifted[15:0] > {10'd0, argc_limit}
									|| shifted[15:0] > 16'(MAX_ARGS)) begin
								code_n  = {13'd0, cfdc_pkg::ERR_COUNT};
								phase_n = cfdc_pkg::PH_HOLD;
							end else begin
								count_n = shifted[cfdc_pkg::CNT_W-1:0];
								phase_n = (shifted[15:0] == 16'd0) ?
									cfdc_pkg::PH_TAIL : cfdc_pkg::PH_ARGS;
								pos_n   = '0;
							end
						end
					end
					cfdc_pkg::PH_HOLD: begin
						pos_n = pos_q + 8'd1;
						// held error waits for the twelfth byte of the buffer
						if (pos_q >= 8'd11) begin
							job_push          = 1'b1;
							job_data.is_err   = 1'b1;
							job_data.err_code = code_q[2:0];
							decided           = 1'b1;
						end
					end
					cfdc_pkg::PH_ARGS: begin
						crc_n = crc_byte;
						if (pos_q[1:0] == 2'd3) begin
							ram_we  = 1'b1;
							shift_n = '0;
						end
						if ({1'b0, pos_q} + 9'd1 >= {1'b0, count_q, 2'b00}) begin
							phase_n = cfdc_pkg::PH_TAIL;
							pos_n   = '0;
						end else begin
							pos_n = pos_q + 8'd1;
						end
					end
					cfdc_pkg::PH_TAIL: begin
						pos_n = pos_q + 8'd1;
						if (pos_q == 8'd1) begin
							// from here on crc_q holds the mismatch flag
							crc_n   = {15'd0, shifted[15:0] != crc_q};
							shift_n = '0;
						end else if (pos_q == 8'd5) begin
							job_push = 1'b1;
							decided  = 1'b1;
							if (crc_q != 16'd0) begin
								job_data.is_err   = 1'b1;
								job_data.err_code = cfdc_pkg::ERR_CRC;
							end else if (shifted != footer_word) begin
								job_data.is_err   = 1'b1;
								job_data.err_code = cfdc_pkg::ERR_FOOTER;
							end else begin
								job_data.code  = code_q;
								job_data.count = count_q;
							end
						end
					end
					default: begin
						phase_n = cfdc_pkg::PH_HEADER;
					end
				endcase

				if (decided) begin
					if (buffer_end) begin
						phase_n = cfdc_pkg::PH_HEADER;
						pos_n   = '0;
						crc_n   = '0;
						shift_n = '0;
						code_n  = '0;
						count_n = '0;
					end else begin
						skip_n = 1'b1;
					end
				end else if (buffer_end) begin
					job_push          = 1'b1;
					job_data          = '0;
					job_data.is_err   = 1'b1;
					job_data.err_code = cfdc_pkg::ERR_SHORT;
					phase_n = cfdc_pkg::PH_HEADER;
					pos_n   = '0;
					crc_n   = '0;
					shift_n = '0;
					code_n  = '0;
					count_n = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfdc_pkg::PH_HEADER;
			pos_q   <= '0;
			crc_q   <= '0;
			shift_q <= '0;
			code_q  <= '0;
			count_q <= '0;
			skip_q  <= 1'b0;
		end else begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			crc_q   <= crc_n;
			shift_q <= shift_n;
			code_q  <= code_n;
			count_q <= count_n;
			skip_q  <= skip_n;
		end
	end

endmodule

[design/cfdc_job_fifo.sv]
// ----------------------------------------------------------------------------
// cfdc_job_fifo
// Short queue of decided frames between parser and emitter.
// ----------------------------------------------------------------------------
module cfdc_job_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cfdc_pkg::job_t push_data,
	input  logic           pop,
	output cfdc_pkg::job_t head,
	output logic           full,
	output logic           empty
);

	localparam int PW = (cfdc_pkg::JOB_DEPTH > 1) ? $clog2(cfdc_pkg::JOB_DEPTH) : 1;
	localparam int CW = $clog2(cfdc_pkg::JOB_DEPTH + 1);

	cfdc_pkg::job_t entry_q [cfdc_pkg::JOB_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign head  = entry_q[rd_q];
	assign full  = (cnt_q == CW'(cfdc_pkg::JOB_DEPTH));
	assign empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(cfdc_pkg::JOB_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(cfdc_pkg::JOB_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[design/cfdc_back.sv]
// ----------------------------------------------------------------------------
// cfdc_back
// Result emitter: one error or summary request per job, then, for a summary
// with arguments, replays the stored arguments through the output register.
// ----------------------------------------------------------------------------
module cfdc_back #(
	parameter int MAX_ARGS = cfdc_pkg::MAX_ARGS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            job_valid,
	input  cfdc_pkg::job_t                                  job_head,
	output logic                                            job_pop,
	output logic                                            busy,
	output logic                                            ram_re,
	output logic [((MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1)-1:0] ram_raddr,
	input  logic [31:0]                                     ram_rdata,
	output logic                                            out_valid,
	input  logic                                            out_stall,
	output cfdc_pkg::result_t                               result
);

	localparam int AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

	cfdc_pkg::back_state_t      state_q, state_n;
	logic [cfdc_pkg::CNT_W-1:0] idx_q, idx_n;
	logic [cfdc_pkg::CNT_W-1:0] cnt_q, cnt_n;
	logic [15:0]                code_q, code_n;
	logic                       out_valid_q;
	cfdc_pkg::result_t          out_q, out_n;
	logic                       load;
	logic                       out_free;
	logic                       last_arg;

	assign out_free  = !out_valid_q || !out_stall;
	assign last_arg  = (cfdc_pkg::CNT_W'(idx_q + 1'b1) == cnt_q);
	assign busy      = (state_q != cfdc_pkg::BK_IDLE);
	assign ram_raddr = idx_q[AW-1:0];
	assign out_valid = out_valid_q;
	assign result    = out_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			cfdc_pkg::BK_IDLE: begin
				if (job_valid && out_free && !job_head.is_err && job_head.count != '0) begin
					state_n = cfdc_pkg::BK_READ;
				end
			end
			cfdc_pkg::BK_READ: begin
				state_n = cfdc_pkg::BK_LOAD;
			end
			cfdc_pkg::BK_LOAD: begin
				if (out_free) begin
					state_n = last_arg ? cfdc_pkg::BK_IDLE : cfdc_pkg::BK_READ;
				end
			end
			default: begin
				state_n = cfdc_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		job_pop = 1'b0;
		ram_re  = 1'b0;
		load    = 1'b0;
		out_n   = out_q;
		idx_n   = idx_q;
		cnt_n   = cnt_q;
		code_n  = code_q;
		unique case (state_q)
			cfdc_pkg::BK_IDLE: begin
				if (job_valid && out_free) begin
					job_pop = 1'b1;
					load    = 1'b1;
					out_n   = '0;
					out_n.last = 1'b1;
					if (job_head.is_err) begin
						out_n.kind     = cfdc_pkg::KIND_ERROR;
						out_n.err_code = job_head.err_code;
					end else begin
						out_n.kind  = cfdc_pkg::KIND_SUMMARY;
						out_n.code  = job_head.code;
						out_n.count = job_head.count;
						out_n.last  = (job_head.count == '0);
						code_n      = job_head.code;
						cnt_n       = job_head.count;
						idx_n       = '0;
					end
				end
			end
			cfdc_pkg::BK_READ: begin
				ram_re = 1'b1;
			end
			cfdc_pkg::BK_LOAD: begin
				if (out_free) begin
					load        = 1'b1;
					out_n.kind  = cfdc_pkg::KIND_ARG;
					out_n.code  = code_q;
					out_n.count = cnt_q;
					out_n.index = idx_q[4:0];
					out_n.value = ram_rdata;
					out_n.err_code = cfdc_pkg::ERR_SHORT;
					out_n.last  = last_arg;
					idx_n       = cfdc_pkg::CNT_W'(idx_q + 1'b1);
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfdc_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
			cnt_q   <= cnt_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		code_q <= code_n;
		if (load) begin
			out_q <= out_n;
		end
	end

endmodule

[test/tb_command_frame_deframer_crc16_unit.sv]
// ----------------------------------------------------------------------------
// tb_command_frame_deframer_crc16_unit
// Self-checking bench: feeds framed and broken command buffers byte by byte,
// predicts every summary, argument and error result, and compares them in order.
// ----------------------------------------------------------------------------
module tb_command_frame_deframer_crc16_unit;

	localparam int ARG_SLOTS = cfdc_pkg::MAX_ARGS_DEF;
	localparam int NUM_ROWS  = 17;

	typedef enum logic [2:0] {
		F_NONE,
		F_HEADER,
		F_CRC,
		F_FOOTER,
		F_BOTH
	} frame_fault_t;

	// one directed buffer; len 0 keeps the natural length, else cut or pad to len
	typedef struct packed {
		logic [15:0]  code;
		int           count;
		frame_fault_t fault;
		int           len;
		int           trail;
		bit           typed;
		logic [1:0]   t_kind;
		logic [2:0]   t_err;
	} frame_row_t;

	localparam frame_row_t PLAN [NUM_ROWS] = '{
		'{16'h0000, 0,     F_NONE,   0,  0, 1'b1, cfdc_pkg::KIND_SUMMARY, cfdc_pkg::ERR_SHORT},
		'{16'hFFFF, 0,     F_NONE,   0,  2, 1'b1, cfdc_pkg::KIND_SUMMARY, cfdc_pkg::ERR_SHORT},
		'{16'h1234, 3,     F_NONE,   0,  0, 1'b0, cfdc_pkg::KIND_SUMMARY, cfdc_pkg::ERR_SHORT},
		'{16'hA5A5, 32,    F_NONE,   0,  1, 1'b0, cfdc_pkg::KIND_SUMMARY, cfdc_pkg::ERR_SHORT},
		'{16'h0001, 33,    F_NONE,   0,  0, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_COUNT},
		'{16'h0002, 65535, F_NONE,   16, 0, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_COUNT},
		'{16'h0003, 1,     F_HEADER, 0,  0, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_HEADER},
		'{16'h0004, 0,     F_HEADER, 12, 0, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_HEADER},
		'{16'h0005, 0,     F_HEADER, 11, 0, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_SHORT},
		'{16'h0006, 40,    F_NONE,   11, 0, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_SHORT},
		'{16'h0007, 2,     F_CRC,    0,  0, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_CRC},
		'{16'h0008, 2,     F_FOOTER, 0,  0, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_FOOTER},
		'{16'h0009, 1,     F_BOTH,   0,  3, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_CRC},
		'{16'h000A, 2,     F_NONE,   17, 0, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_SHORT},
		'{16'h000B, 0,     F_NONE,   13, 0, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_SHORT},
		'{16'h000C, 0,     F_NONE,   1,  0, 1'b1, cfdc_pkg::KIND_ERROR,   cfdc_pkg::ERR_SHORT},
		'{16'hBEEF, 5,     F_NONE,   0,  0, 1'b0, cfdc_pkg::KIND_SUMMARY, cfdc_pkg::ERR_SHORT}
	};

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           in_valid   = 1'b0;
	logic [7:0]                     rx_byte    = 8'h00;
	logic                           buffer_end = 1'b0;
	logic                           out_stall  = 1'b0;
	logic                           cfg_valid  = 1'b0;
	logic [cfdc_pkg::CFG_IDX_W-1:0] cfg_index  = cfdc_pkg::CFG_HEADER;
	logic [31:0]                    cfg_data   = 32'h0;
	logic                           in_stall, out_valid, last, cfg_ready;
	logic [1:0]                     kind;
	logic [15:0]                    command_code;
	logic [5:0]                     arg_count;
	logic [4:0]                     arg_index;
	logic [31:0]                    arg_value;
	logic [2:0]                     error_code;

	command_frame_deframer_crc16_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.buffer_end   (buffer_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.command_code (command_code),
		.arg_count    (arg_count),
		.arg_index    (arg_index),
		.arg_value    (arg_value),
		.error_code   (error_code),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser mirror: configuration and frame state
	logic [31:0]      hdr_cfg    = cfdc_pkg::HEADER_RESET;
	logic [31:0]      ftr_cfg    = cfdc_pkg::FOOTER_RESET;
	logic [5:0]       argc_limit = cfdc_pkg::ARGC_LIMIT_RESET;
	cfdc_pkg::phase_t phase      = cfdc_pkg::PH_HEADER;
	int               pos        = 0;
	logic [15:0]      crc_acc    = 16'h0;
	logic             crc_bad    = 1'b0;
	logic [31:0]      shift_reg  = 32'h0;
	logic [15:0]      code_held  = 16'h0;
	logic [5:0]       count_held = 6'd0;
	logic [2:0]       held_err   = cfdc_pkg::ERR_SHORT;
	logic             skipping   = 1'b0;
	logic [31:0]      arg_mem [ARG_SLOTS];

	cfdc_pkg::result_t pending_results [$];
	cfdc_pkg::result_t typed_res;
	bit                typed_active = 1'b0;
	logic [7:0]        frame_bytes [$];
	int                bytes_sent = 0;
	int                fails = 0;

	// receiver control
	logic        hold_go   = 1'b0;
	logic        calm      = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;
	int          stall_left = 0;

	function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb  = acc[0] ^ b[i];
			acc = acc >> 1;
			if (fb)
				acc = acc ^ cfdc_pkg::CRC_POLY;
		end
		return acc;
	endfunction

	function automatic cfdc_pkg::result_t make_result(input logic [1:0] k,
			input logic [15:0] c, input logic [5:0] n, input logic [4:0] ix,
			input logic [31:0] v, input logic [2:0] er, input logic l);
		cfdc_pkg::result_t r;
		r.kind     = k;
		r.code     = c;
		r.count    = n;
		r.index    = ix;
		r.value    = v;
		r.err_code = er;
		r.last     = l;
		return r;
	endfunction

	task automatic rearm_parser();
		pos        = 0;
		phase      = cfdc_pkg::PH_HEADER;
		crc_acc    = 16'h0;
		crc_bad    = 1'b0;
		shift_reg  = 32'h0;
		code_held  = 16'h0;
		count_held = 6'd0;
		held_err   = cfdc_pkg::ERR_SHORT;
		skipping   = 1'b0;
	endtask

	// advance the mirror by one byte and queue what that byte decides
	task automatic deframe_byte(input logic [7:0] b, input logic e);
		cfdc_pkg::result_t got [$];
		bit                decided;
		logic [15:0]       cnt;
		decided = 1'b0;
		if (skipping) begin
			if (e)
				rearm_parser();
			return;
		end
		shift_reg = {shift_reg[23:0], b};
		case (phase)
			cfdc_pkg::PH_HEADER: begin
				crc_acc = crc16_next(crc_acc, b);
				if (pos == 3) begin
					if (shift_reg != hdr_cfg) begin
						held_err = cfdc_pkg::ERR_HEADER;
						phase    = cfdc_pkg::PH_HOLD;
					end else begin
						phase = cfdc_pkg::PH_CODE;
					end
					shift_reg = 32'h0;
				end
				pos++;
			end
			cfdc_pkg::PH_CODE: begin
				crc_acc = crc16_next(crc_acc, b);
				if (pos == 5) begin
					code_held = shift_reg[15:0];
					shift_reg = 32'h0;
					pos++;
				end else if (pos == 7) begin
					cnt       = shift_reg[15:0];
					shift_reg = 32'h0;
					if (cnt > argc_limit || cnt > ARG_SLOTS) begin
						held_err = cfdc_pkg::ERR_COUNT;
						phase    = cfdc_pkg::PH_HOLD;
						pos++;
					end else begin
						count_held = cnt[5:0];
						phase      = (cnt == 0) ? cfdc_pkg::PH_TAIL : cfdc_pkg::PH_ARGS;
						pos        = 0;
					end
				end else begin
					pos++;
				end
			end
			cfdc_pkg::PH_HOLD: begin
				// header and count errors wait for the minimum buffer length
				if (pos >= 11) begin
					got = {got, make_result(cfdc_pkg::KIND_ERROR, '0, '0, '0, '0,
						held_err, 1'b1)};
					decided = 1'b1;
				end
				pos++;
			end
			cfdc_pkg::PH_ARGS: begin
				crc_acc = crc16_next(crc_acc, b);
				if (pos[1:0] == 2'd3) begin
					arg_mem[(pos >> 2) % ARG_SLOTS] = shift_reg;
					shift_reg = 32'h0;
				end
				if (pos + 1 >= count_held * 4) begin
					phase = cfdc_pkg::PH_TAIL;
					pos   = 0;
				end else begin
					pos++;
				end
			end
			cfdc_pkg::PH_TAIL: begin
				if (pos == 1) begin
					crc_bad   = (shift_reg[15:0] != crc_acc);
					shift_reg = 32'h0;
				end else if (pos == 5) begin
					if (crc_bad)
						got = {got, make_result(cfdc_pkg::KIND_ERROR, '0, '0, '0, '0,
							cfdc_pkg::ERR_CRC, 1'b1)};
					else if (shift_reg != ftr_cfg)
						got = {got, make_result(cfdc_pkg::KIND_ERROR, '0, '0, '0, '0,
							cfdc_pkg::ERR_FOOTER, 1'b1)};
					else begin
						got = {got, make_result(cfdc_pkg::KIND_SUMMARY, code_held,
							count_held, '0, '0, '0, count_held == 0)};
						for (int i = 0; i < count_held && i < ARG_SLOTS; i++)
							got = {got, make_result(cfdc_pkg::KIND_ARG, code_held,
								count_held, i[4:0], arg_mem[i], '0, i + 1 == count_held)};
					end
					decided = 1'b1;
				end
				pos++;
			end
			default: ;
		endcase
		if (decided) begin
			if (e)
				rearm_parser();
			else
				skipping = 1'b1;
		end else if (e) begin
			got = {got, make_result(cfdc_pkg::KIND_ERROR, '0, '0, '0, '0,
				cfdc_pkg::ERR_SHORT, 1'b1)};
			rearm_parser();
		end
		if (typed_active && got.size() != 0)
			pending_results = {pending_results, typed_res};
		else
			foreach (got[k])
				pending_results = {pending_results, got[k]};
	endtask

	// one input request; returns at the edge that accepts it
	task automatic put_byte(input logic [7:0] b, input logic e);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		rx_byte    <= b;
		buffer_end <= e;
		deframe_byte(b, e);
		bytes_sent++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic push_be(input logic [31:0] w, input int n);
		for (int k = n - 1; k >= 0; k--)
			frame_bytes = {frame_bytes, w[8*k +: 8]};
	endtask

	task automatic send_buffer();
		for (int i = 0; i < frame_bytes.size(); i++)
			put_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	task automatic send_frame(input logic [15:0] code, input int count,
			input frame_fault_t fault, input int len, input int trail);
		logic [31:0] w;
		logic [15:0] crc;
		int          nwords;
		frame_bytes.delete();
		w = hdr_cfg;
		if (fault == F_HEADER)
			w = w ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
		push_be(w, 4);
		push_be({16'h0, code}, 2);
		push_be(32'(count), 2);
		nwords = (count <= ARG_SLOTS) ? count : 0;
		for (int i = 0; i < nwords; i++) begin
			w = ($urandom_range(0, 5) == 0) ? 32'h0 :
				($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom();
			push_be(w, 4);
		end
		crc = 16'h0;
		foreach (frame_bytes[i])
			crc = crc16_next(crc, frame_bytes[i]);
		if (fault == F_CRC || fault == F_BOTH)
			crc = crc ^ 16'($urandom_range(1, 65535));
		push_be({16'h0, crc}, 2);
		w = ftr_cfg;
		if (fault == F_FOOTER || fault == F_BOTH)
			w = w ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
		push_be(w, 4);
		repeat (trail)
			frame_bytes = {frame_bytes, 8'($urandom())};
		if (len > 0) begin
			while (frame_bytes.size() > len)
				void'(frame_bytes.pop_back());
			while (frame_bytes.size() < len)
				frame_bytes = {frame_bytes, 8'($urandom())};
		end
		send_buffer();
	endtask

	// well-formed frames with random content, plus faulted, cut and noise buffers
	task automatic run_random(input int budget);
		int           stop, sel, cnt, len, trail, cap;
		frame_fault_t f;
		stop = bytes_sent + budget;
		while (bytes_sent < stop) begin
			sel   = $urandom_range(0, 99);
			f     = F_NONE;
			len   = 0;
			trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
			cap   = (argc_limit < 4) ? int'(argc_limit) : 4;
			cnt   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, int'(argc_limit)) :
				$urandom_range(0, cap);
			if (sel < 15) begin
				frame_bytes.delete();
				len = $urandom_range(1, 24);
				if ($urandom_range(0, 1))
					push_be(hdr_cfg, 4);
				while (frame_bytes.size() > len)
					void'(frame_bytes.pop_back());
				while (frame_bytes.size() < len)
					frame_bytes = {frame_bytes, 8'($urandom())};
				send_buffer();
			end else begin
				if (sel >= 60 && sel < 68)
					f = F_HEADER;
				else if (sel >= 68 && sel < 76)
					cnt = $urandom_range(0, 1) ? int'(argc_limit) + 1 + $urandom_range(0, 2) :
						$urandom_range(int'(argc_limit) + 1, 65535);
				else if (sel >= 76 && sel < 84)
					f = F_CRC;
				else if (sel >= 84 && sel < 90)
					f = F_FOOTER;
				else if (sel >= 90 && sel < 93)
					f = F_BOTH;
				else if (sel >= 93)
					len = $urandom_range(1, 13 + 4 * cnt);
				send_frame(16'($urandom()), cnt, f, len, trail);
			end
		end
	endtask

	task automatic write_reg(input logic [cfdc_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			cfdc_pkg::CFG_HEADER:     hdr_cfg    = data;
			cfdc_pkg::CFG_FOOTER:     ftr_cfg    = data;
			cfdc_pkg::CFG_ARGC_LIMIT: argc_limit = data[5:0];
			default: ;
		endcase
	endtask

	task automatic check_result();
		cfdc_pkg::result_t want;
		if (pending_results.size() == 0) begin
			$error("unexpected result: kind %0d code %0d", kind, error_code);
			fails++;
			return;
		end
		want = pending_results.pop_front();
		if (kind !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, kind);
			fails++;
		end
		if (command_code !== want.code) begin
			$error("command_code: expected %h, got %h", want.code, command_code);
			fails++;
		end
		if (arg_count !== want.count) begin
			$error("arg_count: expected %0d, got %0d", want.count, arg_count);
			fails++;
		end
		if (arg_index !== want.index) begin
			$error("arg_index: expected %0d, got %0d", want.index, arg_index);
			fails++;
		end
		if (arg_value !== want.value) begin
			$error("arg_value: expected %h, got %h", want.value, arg_value);
			fails++;
		end
		if (error_code !== want.err_code) begin
			$error("error_code: expected %0d, got %0d", want.err_code, error_code);
			fails++;
		end
		if (last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, last);
			fails++;
		end
	endtask

	// output side: check each accepted request, then pick the next stall value
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_go && !hold_done) begin
				// long hold so the frame queue fills and input backs up
				hold_done = 1'b1;
				hold_left = 300;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 6);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		rearm_parser();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			typed_active = PLAN[i].typed;
			if (PLAN[i].t_kind == cfdc_pkg::KIND_SUMMARY)
				typed_res = make_result(cfdc_pkg::KIND_SUMMARY, PLAN[i].code,
					PLAN[i].count[5:0], '0, '0, '0, 1'b1);
			else
				typed_res = make_result(cfdc_pkg::KIND_ERROR, '0, '0, '0, '0,
					PLAN[i].t_err, 1'b1);
			send_frame(PLAN[i].code, PLAN[i].count, PLAN[i].fault, PLAN[i].len,
				PLAN[i].trail);
		end
		typed_active = 1'b0;

		write_reg(cfdc_pkg::CFG_HEADER, $urandom());
		write_reg(cfdc_pkg::CFG_FOOTER, $urandom());
		write_reg(cfdc_pkg::CFG_ARGC_LIMIT, 32'd0);
		run_random(10);

		write_reg(cfdc_pkg::CFG_HEADER, 32'h0);
		write_reg(cfdc_pkg::CFG_FOOTER, 32'hFFFF_FFFF);
		write_reg(cfdc_pkg::CFG_ARGC_LIMIT, 32'd32);
		hold_go <= 1'b1;
		run_random(60);

		write_reg(cfdc_pkg::CFG_HEADER, 32'hFFFF_FFFF);
		write_reg(cfdc_pkg::CFG_FOOTER, 32'h0);
		write_reg(cfdc_pkg::CFG_ARGC_LIMIT, $urandom_range(1, 31));
		run_random(15);

		write_reg(cfdc_pkg::CFG_HEADER, $urandom());
		write_reg(cfdc_pkg::CFG_FOOTER, $urandom());
		write_reg(cfdc_pkg::CFG_ARGC_LIMIT, $urandom_range(1, 32));
		calm <= 1'b1;
		run_random(15);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
